FILE: rtl/cisv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisv_pkg: shared types and constants of the CBOR item skip validator
// Field widths, CBOR header codes, result codes, and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cisv_pkg;

	localparam int unsigned DEF_MAX_DEPTH = 8;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned BUDGET_W = 16;
	localparam int unsigned BASE_W   = 4;
	localparam int unsigned KIDS_W   = 17;
	localparam int unsigned ARG_W    = 64;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_DEPTH   = 1'd1;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd4096;
	localparam logic [BASE_W-1:0]   BASE_RESET   = 4'd0;

	// CBOR major types.
	localparam logic [2:0] MAJ_UINT   = 3'd0;
	localparam logic [2:0] MAJ_NINT   = 3'd1;
	localparam logic [2:0] MAJ_BSTR   = 3'd2;
	localparam logic [2:0] MAJ_TSTR   = 3'd3;
	localparam logic [2:0] MAJ_ARRAY  = 3'd4;
	localparam logic [2:0] MAJ_MAP    = 3'd5;
	localparam logic [2:0] MAJ_TAG    = 3'd6;
	localparam logic [2:0] MAJ_SIMPLE = 3'd7;

	// Additional-info codes.
	localparam logic [4:0] INFO_FALSE = 5'd20;
	localparam logic [4:0] INFO_NULL  = 5'd22;
	localparam logic [4:0] INFO_ARG1  = 5'd24;
	localparam logic [4:0] INFO_RSVD  = 5'd28;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_TRUNC     = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_LIMIT     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_END  = 2'd1,
		EV_ERR  = 2'd2
	} event_t;

	// Controller to datapath.
	typedef struct packed {
		logic step;   // a byte is accepted this cycle
		logic close;  // one more level of the container close cascade
		logic fin;    // settle the current outcome (emit and buffer bookkeeping)
		logic held;   // the outcome to settle is the one stored earlier
		logic hold;   // store the current outcome, the output register is busy
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic resolved;    // outcome of the beat is known this cycle
		logic need_close;  // a container closed and the next level must be checked
		logic emit;        // the outcome produces a result
	} stat_t;

endpackage

FILE: rtl/cisv_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisv_in_if: byte channel into the validator
// One beat carries one byte of the encoded buffer and its last-byte mark.
// ----------------------------------------------------------------------------
interface cisv_in_if;
	logic                        valid;
	logic                        ready;
	logic [cisv_pkg::DATA_W-1:0] data_byte;
	logic                        is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

FILE: rtl/cisv_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisv_out_if: result channel of the validator
// One beat carries the status, byte count and remaining container budget.
// ----------------------------------------------------------------------------
interface cisv_out_if;
	logic                          valid;
	logic                          ready;
	logic [cisv_pkg::STATUS_W-1:0] status;
	logic [cisv_pkg::COUNT_W-1:0]  byte_count;
	logic [cisv_pkg::BUDGET_W-1:0] budget_left;

	modport source (output valid, output status, output byte_count, output budget_left,
		input ready);
	modport sink (input valid, input status, input byte_count, input budget_left,
		output ready);
endinterface

FILE: rtl/cisv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisv_ctrl: sequencing controller of the validator
// Accepts bytes, runs the container close cascade one level per cycle and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module cisv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output cisv_pkg::cmd_t   cmd,
	input  cisv_pkg::stat_t  st
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CLOSE,
		S_WAIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;
	logic   out_free;
	logic   busy_done;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.step  = (state_q == S_IDLE) && in_valid;
		cmd.close = (state_q == S_CLOSE);
		cmd.held  = (state_q == S_WAIT);
		busy_done = (cmd.step || cmd.close) && st.resolved;
		cmd.fin   = (busy_done || cmd.held) && (!st.emit || out_free);
		cmd.hold  = busy_done && st.emit && !out_free;

		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.step && st.need_close) begin
					state_d = S_CLOSE;
				end else if (cmd.hold) begin
					state_d = S_WAIT;
				end
			end
			S_CLOSE: begin
				if (st.need_close) begin
					state_d = S_CLOSE;
				end else if (cmd.hold) begin
					state_d = S_WAIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WAIT: begin
				if (cmd.fin) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cmd.fin && st.emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// A held result only exists while the output register is occupied.
	a_wait_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |-> out_valid_q)
		else $error("waiting for the output register while it is empty");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && st.emit) |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending beat");

endmodule

FILE: rtl/cisv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisv_dp: datapath of the validator
// Header and argument decoding, string payload skipping, the stack of child
// counters, budget and depth checks, byte counting and the output register.
// ----------------------------------------------------------------------------
module cisv_dp #(
	parameter int unsigned MAX_DEPTH = cisv_pkg::DEF_MAX_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cisv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cisv_pkg::BUDGET_W-1:0]       cfg_wdata,
	input  logic [cisv_pkg::DATA_W-1:0]         data_byte,
	input  logic                                is_last,
	input  cisv_pkg::cmd_t                      cmd,
	output cisv_pkg::stat_t                     st,
	output logic [cisv_pkg::STATUS_W-1:0]       status,
	output logic [cisv_pkg::COUNT_W-1:0]        byte_count,
	output logic [cisv_pkg::BUDGET_W-1:0]       budget_left
);

	localparam int unsigned BUDGET_W = cisv_pkg::BUDGET_W;
	localparam int unsigned BASE_W   = cisv_pkg::BASE_W;
	localparam int unsigned COUNT_W  = cisv_pkg::COUNT_W;
	localparam int unsigned KIDS_W   = cisv_pkg::KIDS_W;
	localparam int unsigned ARG_W    = cisv_pkg::ARG_W;
	localparam int unsigned OPEN_W   = $clog2(MAX_DEPTH + 1);
	localparam int unsigned IDX_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned BASE_MAX = (1 << BASE_W) - 1;
	localparam int unsigned NEST_MAX = (MAX_DEPTH > BASE_MAX) ? MAX_DEPTH : BASE_MAX;
	localparam int unsigned NEST_W   = $clog2(NEST_MAX + 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_ARG,
		PH_PAYLOAD,
		PH_DRAIN
	} phase_t;

	// Control state.
	logic [BUDGET_W-1:0] budget_start_q;
	logic [BASE_W-1:0]   base_depth_q;
	phase_t              phase_q, phase_d;
	logic [NEST_W-1:0]   nest_q, nest_d;
	logic [OPEN_W-1:0]   open_q, open_d;
	logic [BUDGET_W-1:0] budget_q, budget_d;
	logic [COUNT_W-1:0]  consumed_q, consumed_d;
	logic                fresh_q, fresh_d;
	logic                last_q, last_d;
	cisv_pkg::event_t    ev_q, ev_d;

	// Payload state.
	logic [3:0]          arg_left_q, arg_left_d;
	logic [1:0]          arg_wsel_q, arg_wsel_d;
	logic [ARG_W-1:0]    arg_value_q, arg_value_d;
	logic [2:0]          major_q, major_d;
	logic [ARG_W-1:0]    payload_q, payload_d;
	cisv_pkg::status_t   code_q, code_d;
	logic [KIDS_W-1:0]   stack_q [MAX_DEPTH];
	cisv_pkg::status_t   status_q, status_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [BUDGET_W-1:0] left_q, left_d;
	logic                out_load;

	// Working signals.
	logic [BUDGET_W-1:0] budget_e;
	logic [NEST_W-1:0]   nest_e, nest_cur;
	logic [OPEN_W-1:0]   open_e, open_cur;
	logic [IDX_W-1:0]    top_idx;
	logic [KIDS_W-1:0]   top_dec;
	logic [4:0]          info;
	logic [2:0]          maj;
	logic [ARG_W-1:0]    arg_next;
	logic [ARG_W-1:0]    arg_v;
	logic                top_zero;
	logic                over;
	logic                setup;
	logic                arg_go;
	logic                leaf;
	logic                do_leaf;
	logic [KIDS_W-1:0]   kids;
	logic                stk_we;
	logic [IDX_W-1:0]    stk_idx;
	logic [KIDS_W-1:0]   stk_data;
	cisv_pkg::event_t    ev_now, ev_sel;
	cisv_pkg::status_t   code_now, code_sel;
	logic                last_sel;
	logic                drain_step;

	always_comb begin
		// The first byte of a buffer sees the configured budget and depth.
		budget_e = fresh_q ? budget_start_q : budget_q;
		nest_e   = fresh_q ? NEST_W'(base_depth_q) : nest_q;
		open_e   = fresh_q ? '0 : open_q;
		open_cur = cmd.step ? open_e : open_q;
		nest_cur = cmd.step ? nest_e : nest_q;
		top_idx  = IDX_W'(open_cur - OPEN_W'(1));
		top_dec  = stack_q[top_idx] - KIDS_W'(1);

		info     = data_byte[4:0];
		maj      = data_byte[7:5];
		arg_next = {arg_value_q[ARG_W-9:0], data_byte};

		// A multi-byte argument whose leading byte is zero fits a narrower form.
		case (arg_wsel_q)
			2'd1:    top_zero = (arg_next[15:8] == 8'd0);
			2'd2:    top_zero = (arg_next[31:24] == 8'd0);
			2'd3:    top_zero = (arg_next[63:56] == 8'd0);
			default: top_zero = 1'b0;
		endcase

		phase_d     = phase_q;
		nest_d      = nest_q;
		open_d      = open_q;
		budget_d    = budget_q;
		consumed_d  = consumed_q;
		fresh_d     = fresh_q;
		last_d      = last_q;
		ev_d        = ev_q;
		code_d      = code_q;
		arg_left_d  = arg_left_q;
		arg_wsel_d  = arg_wsel_q;
		arg_value_d = arg_value_q;
		major_d     = major_q;
		payload_d   = payload_q;

		stk_we     = 1'b0;
		stk_idx    = top_idx;
		stk_data   = top_dec;
		ev_now     = cisv_pkg::EV_NONE;
		code_now   = cisv_pkg::ST_MALFORMED;
		setup      = 1'b0;
		arg_go     = 1'b0;
		arg_v      = '0;
		leaf       = 1'b0;
		over       = 1'b0;
		kids       = '0;
		drain_step = 1'b0;
		st         = '0;

		if (cmd.step) begin
			last_d   = is_last;
			fresh_d  = 1'b0;
			budget_d = budget_e;
			nest_d   = nest_e;
			open_d   = open_e;
			if (phase_q == PH_DRAIN) begin
				drain_step = 1'b1;
				if (is_last) begin
					phase_d    = PH_HEADER;
					open_d     = '0;
					consumed_d = '0;
					fresh_d    = 1'b1;
				end
			end else begin
				if (consumed_q != '1) begin
					consumed_d = consumed_q + COUNT_W'(1);
				end
				case (phase_q)
					PH_HEADER: begin
						major_d = maj;
						if (info >= cisv_pkg::INFO_RSVD) begin
							ev_now = cisv_pkg::EV_ERR;
						end else if (maj == cisv_pkg::MAJ_SIMPLE) begin
							if (info >= cisv_pkg::INFO_FALSE && info <= cisv_pkg::INFO_NULL) begin
								leaf = 1'b1;
							end else if (info != cisv_pkg::INFO_ARG1) begin
								ev_now = cisv_pkg::EV_ERR;
							end else begin
								setup = 1'b1;
							end
						end else if (info < cisv_pkg::INFO_ARG1) begin
							arg_go = 1'b1;
							arg_v  = ARG_W'(info);
						end else begin
							setup = 1'b1;
						end
					end
					PH_ARG: begin
						arg_value_d = arg_next;
						arg_left_d  = arg_left_q - 4'd1;
						if (arg_left_q == 4'd1) begin
							phase_d = PH_HEADER;
							if (major_q == cisv_pkg::MAJ_SIMPLE) begin
								leaf = 1'b1;
							end else if (arg_wsel_q != 2'd0 && top_zero) begin
								ev_now = cisv_pkg::EV_ERR;
							end else begin
								arg_go = 1'b1;
								arg_v  = arg_next;
							end
						end
					end
					PH_PAYLOAD: begin
						payload_d = payload_q - ARG_W'(1);
						if (payload_q == ARG_W'(1)) begin
							phase_d = PH_HEADER;
							leaf    = 1'b1;
						end
					end
					default: begin
					end
				endcase

				// Argument of 1, 2, 4 or 8 bytes follows the header.
				if (setup) begin
					arg_wsel_d  = info[1:0];
					arg_left_d  = 4'd1 << info[1:0];
					arg_value_d = '0;
					phase_d     = PH_ARG;
				end

				if (arg_go) begin
					over = (arg_v[ARG_W-1:BUDGET_W] != '0) || (arg_v[BUDGET_W-1:0] > budget_e);
					case (major_d)
						cisv_pkg::MAJ_UINT, cisv_pkg::MAJ_NINT: begin
							leaf = 1'b1;
						end
						cisv_pkg::MAJ_BSTR, cisv_pkg::MAJ_TSTR: begin
							if (arg_v == '0) begin
								leaf = 1'b1;
							end else begin
								payload_d = arg_v;
								phase_d   = PH_PAYLOAD;
							end
						end
						cisv_pkg::MAJ_ARRAY, cisv_pkg::MAJ_MAP: begin
							if (over || nest_e >= NEST_W'(MAX_DEPTH)
								|| open_e >= OPEN_W'(MAX_DEPTH)) begin
								ev_now   = cisv_pkg::EV_ERR;
								code_now = cisv_pkg::ST_LIMIT;
							end else begin
								budget_d = budget_e - arg_v[BUDGET_W-1:0];
								if (major_d == cisv_pkg::MAJ_MAP) begin
									kids = {arg_v[BUDGET_W-1:0], 1'b0};
								end else begin
									kids = {1'b0, arg_v[BUDGET_W-1:0]};
								end
								if (arg_v[BUDGET_W-1:0] == '0) begin
									leaf = 1'b1;
								end else begin
									stk_we   = 1'b1;
									stk_idx  = IDX_W'(open_e);
									stk_data = kids;
									open_d   = open_e + OPEN_W'(1);
									nest_d   = nest_e + NEST_W'(1);
								end
							end
						end
						default: begin
							// A tag waits for the item it prefixes.
						end
					endcase
				end
			end
		end

		// One level of the close cascade: the finished child is counted off
		// the innermost open container, which closes in turn when it empties.
		do_leaf = (cmd.step && leaf) || cmd.close;
		if (do_leaf) begin
			if (open_cur == '0) begin
				ev_now = cisv_pkg::EV_END;
			end else begin
				stk_we   = 1'b1;
				stk_idx  = top_idx;
				stk_data = top_dec;
				if (top_dec == '0) begin
					open_d = open_cur - OPEN_W'(1);
					nest_d = nest_cur - NEST_W'(1);
					if (open_cur == OPEN_W'(1)) begin
						ev_now = cisv_pkg::EV_END;
					end else begin
						st.need_close = 1'b1;
					end
				end
			end
		end

		st.resolved = ((cmd.step && !drain_step) || cmd.close) && !st.need_close;

		ev_sel   = cmd.held ? ev_q : ev_now;
		code_sel = cmd.held ? code_q : code_now;
		last_sel = cmd.step ? is_last : last_q;
		st.emit  = (ev_sel != cisv_pkg::EV_NONE) || last_sel;

		if (cmd.hold) begin
			ev_d   = ev_now;
			code_d = code_now;
		end

		out_load = cmd.fin && st.emit;
		count_d  = consumed_d;
		left_d   = budget_d;
		if (ev_sel == cisv_pkg::EV_END) begin
			status_d = cisv_pkg::ST_OK;
		end else if (ev_sel == cisv_pkg::EV_ERR) begin
			status_d = code_sel;
		end else begin
			status_d = cisv_pkg::ST_TRUNC;
		end

		if (out_load) begin
			if (last_sel) begin
				phase_d    = PH_HEADER;
				open_d     = '0;
				consumed_d = '0;
				fresh_d    = 1'b1;
			end else if (ev_sel == cisv_pkg::EV_ERR) begin
				phase_d = PH_DRAIN;
			end else begin
				consumed_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_start_q <= cisv_pkg::BUDGET_RESET;
			base_depth_q   <= cisv_pkg::BASE_RESET;
			phase_q        <= PH_HEADER;
			nest_q         <= NEST_W'(cisv_pkg::BASE_RESET);
			open_q         <= '0;
			budget_q       <= cisv_pkg::BUDGET_RESET;
			consumed_q     <= '0;
			fresh_q        <= 1'b1;
			last_q         <= 1'b0;
			ev_q           <= cisv_pkg::EV_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cisv_pkg::CFG_BUDGET_START: budget_start_q <= cfg_wdata;
					cisv_pkg::CFG_BASE_DEPTH:   base_depth_q   <= cfg_wdata[BASE_W-1:0];
					default: begin
					end
				endcase
			end
			phase_q    <= phase_d;
			nest_q     <= nest_d;
			open_q     <= open_d;
			budget_q   <= budget_d;
			consumed_q <= consumed_d;
			fresh_q    <= fresh_d;
			last_q     <= last_d;
			ev_q       <= ev_d;
		end
	end

	always_ff @(posedge clk) begin
		arg_left_q  <= arg_left_d;
		arg_wsel_q  <= arg_wsel_d;
		arg_value_q <= arg_value_d;
		major_q     <= major_d;
		payload_q   <= payload_d;
		code_q      <= code_d;
		if (stk_we) begin
			stack_q[stk_idx] <= stk_data;
		end
		if (out_load) begin
			status_q <= status_d;
			count_q  <= count_d;
			left_q   <= left_d;
		end
	end

	assign status      = status_q;
	assign byte_count  = count_q;
	assign budget_left = left_q;

	// The stack of child counters never holds more levels than it has entries.
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OPEN_W'(MAX_DEPTH))
		else $error("open container count beyond stack depth");

	// Dropping bytes after an error never happens at the start of a buffer.
	a_drain_not_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DRAIN) |-> !fresh_q)
		else $error("drain phase with a fresh buffer");

endmodule

FILE: rtl/cbor_item_skip_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_item_skip_validator_top: CBOR item skip and well-formedness checker
// Walks complete CBOR items one byte per beat and reports ok with the byte
// count when an item ends, an error at once, or truncated at the last byte.
//
//   channel   direction  beat contents
//   bytes     in         data_byte[7:0], is_last
//   results   out        status[1:0], byte_count[31:0], budget_left[15:0]
//   cfg       in         cfg_we, cfg_index (0 budget_start, 1 base_depth),
//                        cfg_wdata[15:0]
//
// A byte that empties a container nested in another stalls the byte channel
// while the close loop of the controller walks the stack of child counters
// outward; any other byte leaves the controller free for the next one.
// Reset is asynchronous; there is no clearing pass after it.
// A result waits in the output register until taken; the next byte is still
// accepted, and only a byte whose own result finds that register full stalls.
// ----------------------------------------------------------------------------
module cbor_item_skip_validator_top #(
	parameter int unsigned MAX_DEPTH = cisv_pkg::DEF_MAX_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cisv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cisv_pkg::BUDGET_W-1:0]  cfg_wdata,
	cisv_in_if.sink                        bytes,
	cisv_out_if.source                     results
);

	cisv_pkg::cmd_t  cmd;
	cisv_pkg::stat_t st;

	cisv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bytes.valid),
		.in_ready  (bytes.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.st        (st)
	);

	cisv_dp #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.data_byte   (bytes.data_byte),
		.is_last     (bytes.is_last),
		.cmd         (cmd),
		.st          (st),
		.status      (results.status),
		.byte_count  (results.byte_count),
		.budget_left (results.budget_left)
	);

endmodule

FILE: bench/tb_cbor_item_skip_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cbor_item_skip_validator_top: self-checking bench for the CBOR skipper
// A scripted opening covers the header forms, closing of nested containers,
// tags, simple values, drops after an error and the last-byte rules. Random
// buffers of mostly well-formed items then run under several register
// settings, with idle bursts on both channels and one long result hold-off.
// Every accepted byte goes through a local model of the walker, and every
// result beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cbor_item_skip_validator_top;
	import cisv_pkg::*;

	localparam int unsigned DEPTH         = DEF_MAX_DEPTH;
	localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_BYTES   = 130;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]  byte_count;
		logic [BUDGET_W-1:0] budget_left;
	} verdict_t;

	typedef struct {
		logic [7:0]          data;
		bit                  last;
		bit                  typed;
		status_t             status;
		logic [COUNT_W-1:0]  count;
		logic [BUDGET_W-1:0] budget;
	} script_row_t;

	typedef enum logic [1:0] {W_HEAD, W_ARG, W_PAYLOAD, W_DRAIN} walk_t;

	localparam verdict_t NO_VERDICT = '{ST_OK, 32'd0, 16'd0};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BUDGET_W-1:0] cfg_wdata;

	cisv_in_if bytes_if ();
	cisv_out_if results_if ();

	cbor_item_skip_validator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.bytes     (bytes_if),
		.results   (results_if)
	);

	always #2 clk = ~clk;

	// Walker model state.
	logic [BUDGET_W-1:0] cfg_budget;
	logic [BASE_W-1:0]   cfg_base;
	walk_t               walk;
	int unsigned         arg_left;
	int unsigned         arg_len;
	logic [63:0]         arg_acc;
	logic [2:0]          major;
	logic [63:0]         skip_left;
	int unsigned         depth_now;
	int unsigned         open_levels;
	logic [KIDS_W-1:0]   kids_left [DEPTH];
	logic [BUDGET_W-1:0] budget_avail;
	logic [COUNT_W-1:0]  item_bytes;
	bit                  new_buffer;
	status_t             fail_code;

	verdict_t    verdicts_due [$];
	logic [7:0]  frame [$];
	int unsigned mismatches = 0;
	int unsigned live_bytes = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_rate = 0;
	int unsigned rx_rate = 0;
	int unsigned gen_depth = 4;
	logic        hold_req = 1'b0;
	logic        hold_taken;
	int unsigned rx_wait;

	function automatic void restart_buffer();
		walk = W_HEAD;
		arg_left = 0;
		arg_len = 0;
		arg_acc = '0;
		major = '0;
		skip_left = '0;
		open_levels = 0;
		item_bytes = '0;
		new_buffer = 1'b1;
	endfunction

	function automatic event_t flag_error(input status_t code);
		fail_code = code;
		return EV_ERR;
	endfunction

	// A leaf ended: count it against the innermost open container and close
	// every container whose last child this was.
	function automatic event_t close_levels();
		while (open_levels > 0 && open_levels <= DEPTH) begin
			kids_left[open_levels-1] = kids_left[open_levels-1] - 1'b1;
			if (kids_left[open_levels-1] != 0)
				return EV_NONE;
			open_levels--;
			depth_now--;
		end
		return EV_END;
	endfunction

	function automatic event_t finish_arg(input logic [63:0] v);
		logic [KIDS_W-1:0] kids;
		case (major)
		MAJ_UINT, MAJ_NINT: return close_levels();
		MAJ_BSTR, MAJ_TSTR: begin
			if (v == 0)
				return close_levels();
			skip_left = v;
			walk = W_PAYLOAD;
			return EV_NONE;
		end
		MAJ_ARRAY, MAJ_MAP: begin
			if (v > 64'(budget_avail) || depth_now >= DEPTH || open_levels >= DEPTH)
				return flag_error(ST_LIMIT);
			budget_avail = budget_avail - v[15:0];
			kids = (major == MAJ_MAP) ? {v[15:0], 1'b0} : {1'b0, v[15:0]};
			if (kids == 0)
				return close_levels();
			kids_left[open_levels] = kids;
			open_levels++;
			depth_now++;
			return EV_NONE;
		end
		default: return EV_NONE;
		endcase
	endfunction

	// Advances the model by one byte; returns 1 with the result it causes.
	function automatic bit walk_cbor_byte(input logic [7:0] b, input bit last,
			output verdict_t r);
		event_t ev;
		logic [4:0] info;
		ev = EV_NONE;
		info = b[4:0];
		r = NO_VERDICT;
		if (new_buffer) begin
			budget_avail = cfg_budget;
			depth_now = cfg_base;
			open_levels = 0;
			new_buffer = 1'b0;
		end
		if (walk == W_DRAIN) begin
			if (last)
				restart_buffer();
			return 1'b0;
		end
		if (item_bytes != '1)
			item_bytes++;
		case (walk)
		W_HEAD: begin
			major = b[7:5];
			if (info >= INFO_RSVD)
				ev = flag_error(ST_MALFORMED);
			else if (major == MAJ_SIMPLE && info >= INFO_FALSE && info <= INFO_NULL)
				ev = close_levels();
			else if (major == MAJ_SIMPLE && info != INFO_ARG1)
				ev = flag_error(ST_MALFORMED);
			else if (major != MAJ_SIMPLE && info < INFO_ARG1)
				ev = finish_arg(64'(info));
			else begin
				arg_len = 1 << (info - INFO_ARG1);
				arg_left = arg_len;
				arg_acc = '0;
				walk = W_ARG;
			end
		end
		W_ARG: begin
			arg_acc = {arg_acc[55:0], b};
			if (arg_left > 0)
				arg_left--;
			if (arg_left == 0) begin
				walk = W_HEAD;
				if (major == MAJ_SIMPLE)
					ev = close_levels();
				else if (arg_len > 1 && arg_acc < (64'd1 << (8 * (arg_len - 1))))
					ev = flag_error(ST_MALFORMED);
				else
					ev = finish_arg(arg_acc);
			end
		end
		default: begin
			skip_left--;
			if (skip_left == 0) begin
				walk = W_HEAD;
				ev = close_levels();
			end
		end
		endcase
		if (ev == EV_END)
			r.status = ST_OK;
		else if (ev == EV_ERR)
			r.status = fail_code;
		else if (last)
			r.status = ST_TRUNC;
		else
			return 1'b0;
		r.byte_count = item_bytes;
		r.budget_left = budget_avail;
		if (last)
			restart_buffer();
		else if (ev == EV_ERR)
			walk = W_DRAIN;
		else
			item_bytes = '0;
		return 1'b1;
	endfunction

	// Random argument spread over all five header widths.
	function automatic logic [63:0] pick_arg();
		case ($urandom_range(0, 4))
		0: return 64'($urandom_range(0, 23));
		1: return 64'($urandom_range(24, 255));
		2: return 64'($urandom_range(256, 65535));
		3: return 64'($urandom_range(65536, 32'hFFFF_FFFF));
		default: return {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
		endcase
	endfunction

	function automatic void put_head(input logic [2:0] mj, input logic [63:0] v);
		int lg;
		lg = (v < 24) ? -1 : (v < 256) ? 0 : (v < 65536) ? 1 : (v < 64'h1_0000_0000) ? 2 : 3;
		// Now and then a wider form than needed, which only the one-byte form survives.
		if (lg < 3 && $urandom_range(0, 29) == 0)
			lg++;
		if (lg < 0)
			frame.push_back({mj, v[4:0]});
		else begin
			frame.push_back({mj, INFO_ARG1 + 5'(lg)});
			for (int k = (1 << lg) - 1; k >= 0; k--)
				frame.push_back(v[8*k +: 8]);
		end
	endfunction

	function automatic void put_item(input int unsigned lvl);
		int unsigned pick;
		logic [2:0] mj;
		logic [63:0] n;
		logic [63:0] kids;
		pick = $urandom_range(0, 99);
		if (frame.size() > 60 || (pick >= 40 && pick < 60 && lvl >= gen_depth))
			pick = (pick < 50) ? 0 : 75;
		if (pick < 25) begin
			put_head(3'($urandom_range(MAJ_UINT, MAJ_NINT)), pick_arg());
		end else if (pick < 40) begin
			n = ($urandom_range(0, 9) == 0) ? pick_arg() : 64'($urandom_range(0, 5));
			put_head(3'($urandom_range(MAJ_BSTR, MAJ_TSTR)), n);
			for (int k = 0; k < n && k < 6; k++)
				frame.push_back(8'($urandom));
		end else if (pick < 60) begin
			mj = 3'($urandom_range(MAJ_ARRAY, MAJ_MAP));
			n = ($urandom_range(0, 19) == 0) ? pick_arg() : 64'($urandom_range(0, 3));
			put_head(mj, n);
			kids = (mj == MAJ_MAP) ? 2 * n : n;
			for (int k = 0; k < kids && k < 6; k++)
				put_item(lvl + 1);
		end else if (pick < 70) begin
			put_head(MAJ_TAG, pick_arg());
			put_item(lvl);
		end else if (pick < 90) begin
			if ($urandom_range(0, 3) == 0) begin
				frame.push_back({MAJ_SIMPLE, INFO_ARG1});
				frame.push_back(8'($urandom));
			end else
				frame.push_back({MAJ_SIMPLE, INFO_FALSE + 5'($urandom_range(0, 2))});
		end else begin
			frame.push_back(8'($urandom));
		end
	endfunction

	// One buffer: a few items, sometimes cut short, sometimes pure noise.
	function automatic void build_buffer();
		int unsigned keep;
		frame.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				frame.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 3))
				put_item(0);
			if ($urandom_range(0, 7) == 0) begin
				keep = $urandom_range(1, frame.size());
				while (frame.size() > keep)
					void'(frame.pop_back());
			end
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 50)
			$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Offers one beat, waits for it to be taken and records what it should cause.
	// A typed row's own expectation replaces the model's.
	task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
			input verdict_t given);
		verdict_t guess;
		bit got;
		if (tx_rate != 0 && $urandom_range(0, 99) < tx_rate) begin
			bytes_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= b;
		bytes_if.is_last <= last;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
		if (walk != W_DRAIN)
			live_bytes++;
		got = walk_cbor_byte(b, last, guess);
		if (typed)
			verdicts_due.push_back(given);
		else if (got)
			verdicts_due.push_back(guess);
	endtask

	task automatic settle();
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [BUDGET_W-1:0] budget, input logic [BASE_W-1:0] base);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BUDGET_START;
		cfg_wdata <= budget;
		@(posedge clk);
		cfg_index <= CFG_BASE_DEPTH;
		cfg_wdata <= BUDGET_W'(base);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_budget = budget;
		cfg_base = base;
	endtask

	script_row_t script [28] = '{
		'{8'h00, 1'b0, 1'b1, ST_OK, 32'd1, 16'd4096},
		'{8'h17, 1'b0, 1'b1, ST_OK, 32'd1, 16'd4096},
		'{8'h18, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'hFF, 1'b0, 1'b1, ST_OK, 32'd2, 16'd4096},
		'{8'h19, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h10, 1'b0, 1'b1, ST_MALFORMED, 32'd3, 16'd4096},
		'{8'h00, 1'b1, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'hFC, 1'b1, 1'b1, ST_MALFORMED, 32'd1, 16'd4096},
		'{8'h82, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'hA1, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'hF5, 1'b0, 1'b1, ST_OK, 32'd5, 16'd4093},
		'{8'h80, 1'b0, 1'b1, ST_OK, 32'd1, 16'd4093},
		'{8'hC1, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'hF8, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h20, 1'b0, 1'b1, ST_OK, 32'd3, 16'd4093},
		'{8'hF7, 1'b0, 1'b1, ST_MALFORMED, 32'd1, 16'd4093},
		'{8'h9A, 1'b1, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h9A, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h00, 1'b0, 1'b1, ST_LIMIT, 32'd5, 16'd4096},
		'{8'hFF, 1'b1, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h42, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0},
		'{8'h61, 1'b1, 1'b1, ST_TRUNC, 32'd2, 16'd4096}
	};

	// Result side: idle bursts, plus one long hold-off on request so that the
	// output register stays full and the byte channel backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			rx_wait <= 0;
			hold_taken <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			results_if.ready <= (rx_wait == 1);
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			rx_wait <= HOLD_CYCLES;
			results_if.ready <= 1'b0;
		end else if (rx_rate != 0 && $urandom_range(0, 99) < rx_rate) begin
			rx_wait <= $urandom_range(1, 13);
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d count %0d budget %0d",
					results_if.status, results_if.byte_count, results_if.budget_left));
			end else begin
				want = verdicts_due.pop_front();
				if (results_if.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						results_if.status, want.status));
				if (results_if.byte_count !== want.byte_count)
					report_mismatch($sformatf("byte_count %0d, expected %0d",
						results_if.byte_count, want.byte_count));
				if (results_if.budget_left !== want.budget_left)
					report_mismatch($sformatf("budget_left %0d, expected %0d",
						results_if.budget_left, want.budget_left));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [BUDGET_W-1:0] budget;
		logic [BASE_W-1:0] base;
		int unsigned mark;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BUDGET_START;
		cfg_wdata <= '0;
		bytes_if.valid <= 1'b0;
		bytes_if.data_byte <= '0;
		bytes_if.is_last <= 1'b0;
		cfg_budget = BUDGET_RESET;
		cfg_base = BASE_RESET;
		budget_avail = BUDGET_RESET;
		depth_now = BASE_RESET;
		foreach (kids_left[i])
			kids_left[i] = '0;
		restart_buffer();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_rate = 15;
		rx_rate = 15;
		foreach (script[i])
			send_byte(script[i].data, script[i].last, script[i].typed,
				verdict_t'{script[i].status, script[i].count, script[i].budget});
		bytes_if.valid <= 1'b0;
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
			0: begin
				budget = BUDGET_RESET; base = BASE_RESET;
				tx_rate = 20; rx_rate = 20; gen_depth = 4;
			end
			1: begin
				budget = '0; base = '0;
				tx_rate = 10; rx_rate = 30; gen_depth = 3;
			end
			2: begin
				budget = '1; base = BASE_W'(DEPTH);
				tx_rate = 30; rx_rate = 10; gen_depth = 3;
			end
			3: begin
				budget = 16'd16; base = BASE_W'(DEPTH - 2);
				tx_rate = 20; rx_rate = 20; gen_depth = 6;
			end
			4: begin
				// The sender keeps offering while the result side holds off.
				budget = 16'($urandom_range(0, 64)); base = 4'($urandom_range(0, 3));
				tx_rate = 0; rx_rate = 0; gen_depth = 10;
				hold_req <= 1'b1;
			end
			5: begin
				budget = 16'($urandom); base = 4'($urandom_range(0, DEPTH));
				tx_rate = 25; rx_rate = 25; gen_depth = 9;
			end
			default: begin
				budget = BUDGET_RESET; base = BASE_RESET;
				tx_rate = 0; rx_rate = 0; gen_depth = 5;
			end
			endcase
			set_regs(budget, base);
			mark = live_bytes;
			while (live_bytes - mark < PHASE_BYTES) begin
				build_buffer();
				foreach (frame[k])
					send_byte(frame[k], k == frame.size() - 1, 1'b0, NO_VERDICT);
			end
			bytes_if.valid <= 1'b0;
			settle();
		end

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
